@@ rtl/wsd_pkg.sv @@
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; imported by every module of the block.
`default_nettype none

package wsd_pkg;

   // Width of the frame length register; it holds a full 64-bit extended length.
   localparam int LengthBits = 64;

   localparam logic [3:0] CloseOpcode = 4'h8;
   localparam logic [6:0] Len16Code   = 7'd126;
   localparam logic [6:0] Len64Code   = 7'd127;

   typedef logic [LengthBits-1:0] len_type;

   typedef enum logic [5:0] {
      PH_HEADER  = 6'b000001,
      PH_LEN16   = 6'b000010,
      PH_LEN64   = 6'b000100,
      PH_MASK    = 6'b001000,
      PH_PAYLOAD = 6'b010000,
      PH_DONE    = 6'b100000
   } phase_type;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_EMPTY = 2'd1,
      KIND_CLOSE = 2'd2,
      KIND_ERROR = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] payload_byte;
      logic [3:0] frame_opcode;
      logic       last;
   } rsp_item_type;

endpackage

`default_nettype wire

@@ rtl/wsd_decode.sv @@
// Frame phase machine: header, extended length, mask key and payload unmasking.
// Depends on wsd_pkg.
`default_nettype none

module wsd_decode (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 take,
   input  wire                 operation,
   input  wire [7:0]           data_byte,
   output logic                result_valid,
   output wsd_pkg::rsp_item_type result_item
);
   import wsd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [2:0]  step_ff, step_in;
   logic [3:0]  opcode_ff, opcode_in;
   len_type     remain_ff, remain_in;
   logic [7:0]  key_ff [4];
   logic [7:0]  key_in [4];
   logic [6:0]  len7;

   assign len7 = data_byte[6:0];

   always_comb begin
      phase_in     = phase_ff;
      step_in      = step_ff;
      opcode_in    = opcode_ff;
      remain_in    = remain_ff;
      key_in       = key_ff;
      result_valid = 1'b0;
      result_item.kind         = KIND_DATA;
      result_item.payload_byte = 8'd0;
      result_item.last         = 1'b1;

      if (operation) begin
         phase_in  = PH_HEADER;
         step_in   = 3'd0;
         opcode_in = 4'd0;
         remain_in = '0;
         for (int i = 0; i < 4; i++) begin
            key_in[i] = 8'd0;
         end
      end else begin
         unique case (phase_ff) inside
            PH_HEADER: begin
               if (step_ff == 3'd0) begin
                  opcode_in = data_byte[3:0];
                  if (data_byte[3:0] == CloseOpcode) begin
                     phase_in         = PH_DONE;
                     result_valid     = 1'b1;
                     result_item.kind = KIND_CLOSE;
                  end else begin
                     step_in = 3'd1;
                  end
               end else begin
                  step_in = 3'd0;
                  if (len7 == Len16Code) begin
                     remain_in = '0;
                     phase_in  = PH_LEN16;
                  end else if (len7 == Len64Code) begin
                     remain_in = '0;
                     phase_in  = PH_LEN64;
                  end else begin
                     remain_in = len_type'(len7);
                     if (!data_byte[7] && len7 == 7'd0) begin
                        phase_in         = PH_HEADER;
                        result_valid     = 1'b1;
                        result_item.kind = KIND_EMPTY;
                     end else begin
                        phase_in = data_byte[7] ? PH_MASK : PH_PAYLOAD;
                     end
                  end
               end
            end
            PH_LEN16, PH_LEN64: begin
               remain_in = {remain_ff[LengthBits-9:0], data_byte};
               step_in   = step_ff + 3'd1;
               if ((phase_ff == PH_LEN16 && step_ff == 3'd1) ||
                   (phase_ff == PH_LEN64 && step_ff == 3'd7)) begin
                  phase_in = PH_MASK;
                  step_in  = 3'd0;
               end
            end
            PH_MASK: begin
               key_in[step_ff[1:0]] = data_byte;
               step_in = step_ff + 3'd1;
               if (step_ff == 3'd3) begin
                  step_in = 3'd0;
                  if (remain_ff == '0) begin
                     phase_in         = PH_HEADER;
                     result_valid     = 1'b1;
                     result_item.kind = KIND_EMPTY;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               // remain counts down; only the low two index bits pick the key byte
               result_valid             = 1'b1;
               result_item.kind         = KIND_DATA;
               result_item.payload_byte = data_byte ^ key_ff[step_ff[1:0]];
               remain_in = remain_ff - len_type'(1);
               step_in   = step_ff + 3'd1;
               if (remain_ff == len_type'(1)) begin
                  phase_in = PH_HEADER;
                  step_in  = 3'd0;
               end else begin
                  result_item.last = 1'b0;
               end
            end
            default: begin
               result_valid     = 1'b1;
               result_item.kind = KIND_ERROR;
            end
         endcase
      end
      result_item.frame_opcode = opcode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         step_ff   <= 3'd0;
         opcode_ff <= 4'd0;
         remain_ff <= '0;
         for (int i = 0; i < 4; i++) begin
            key_ff[i] <= 8'd0;
         end
      end else if (take) begin
         phase_ff  <= phase_in;
         step_ff   <= step_in;
         opcode_ff <= opcode_in;
         remain_ff <= remain_in;
         key_ff    <= key_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/wsd_out_buf.sv @@
// Two-entry result queue between the phase machine and the result port.
// Depends on wsd_pkg.
`default_nettype none

module wsd_out_buf (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push,
   input  wsd_pkg::rsp_item_type push_item,
   output logic                  has_room,
   output logic                  out_valid,
   input  wire                   out_ready,
   output wsd_pkg::rsp_item_type out_item
);
   import wsd_pkg::*;

   logic [1:0]   count_ff, count_in;
   rsp_item_type head_ff, head_in;
   rsp_item_type skid_ff, skid_in;
   logic         pop;

   assign has_room  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_item  = head_ff;
   assign pop       = out_valid && out_ready;

   always_comb begin
      head_in  = head_ff;
      skid_in  = skid_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
      if (pop) begin
         head_in = (count_ff == 2'd2) ? skid_ff : push_item;
      end else if (count_ff == 2'd0) begin
         head_in = push_item;
      end
      if (push && ((count_ff == 2'd1 && !pop) || (count_ff == 2'd2 && pop))) begin
         skid_in = push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

endmodule

`default_nettype wire

@@ rtl/websocket_frame_deframer.sv @@
// WebSocket client-to-server deframer, top level: ports and output queue.
// Depends on wsd_pkg, wsd_decode and wsd_out_buf.
`default_nettype none

// Takes one received byte (or a restart request) per cycle and gives at most one
// result per byte: an unmasked payload byte with its frame opcode, an empty-frame
// mark, a close mark, or an error for each byte after a close until restart.
// The phase machine updates its state in the cycle the request is accepted and
// the result lands in a two-entry output queue, so req_tready drops only when
// both queue entries are waiting on the result side. Restarts produce no result,
// nor do header, length and mask bytes but those giving a close or empty mark.
module websocket_frame_deframer (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [7:0] data_byte
   input  wire  [0:0]  req_tuser,   // [0] operation (1 = restart)
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] payload_byte, [11:8] frame_opcode, [15:12] zero
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast
);
   import wsd_pkg::*;

   logic         take;
   logic         result_valid;
   rsp_item_type result_item;
   rsp_item_type out_item;

   assign take = req_tvalid && req_tready;

   wsd_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .operation    (req_tuser[0]),
      .data_byte    (req_tdata),
      .result_valid (result_valid),
      .result_item  (result_item)
   );

   wsd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (take && result_valid),
      .push_item (result_item),
      .has_room  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item)
   );

   assign rsp_tdata = {4'd0, out_item.frame_opcode, out_item.payload_byte};
   assign rsp_tuser = out_item.kind;
   assign rsp_tlast = out_item.last;

endmodule

`default_nettype wire

@@ sim/tb_websocket_frame_deframer.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for websocket_frame_deframer: directed and random frames.
// Depends on wsd_pkg and the deframer RTL.

module tb_websocket_frame_deframer;
   import wsd_pkg::*;

   localparam int CycleLimit  = 200000;
   localparam int RandomItems = 340;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] data_byte
   logic [0:0]  req_tuser = 1'b0;    // [0] operation (1 = restart)
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;           // [7:0] payload_byte, [11:8] frame_opcode, [15:12] zero
   logic [1:0]  rsp_tuser;           // [1:0] kind
   logic        rsp_tlast;

   websocket_frame_deframer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Deframer state mirror
   phase_type   rx_phase  = PH_HEADER;
   logic [63:0] rx_index  = '0;
   logic [3:0]  rx_opcode = '0;
   len_type     rx_length = '0;
   logic [7:0]  rx_mask [4] = '{default: 8'h00};

   rsp_item_type pending_decodes[$];
   logic [7:0]   frame_bytes[$];

   int  error_count    = 0;
   int  requests_sent  = 0;
   int  results_seen   = 0;
   int  kind_seen [4]  = '{default: 0};
   int  cycle_count    = 0;
   bit  idle_on        = 1'b1;
   int  rsp_wait       = 0;
   int  rsp_hold       = 0;

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("ERROR %0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      error_count++;
   endtask

   function automatic void push_decode(kind_type kind, logic [7:0] data, logic last);
      rsp_item_type item;
      item.kind         = kind;
      item.payload_byte = data;
      item.frame_opcode = rx_opcode;
      item.last         = last;
      pending_decodes.insert(pending_decodes.size(), item);
   endfunction

   function automatic void add_frame_byte(logic [7:0] value);
      frame_bytes.insert(frame_bytes.size(), value);
   endfunction

   // Advance the mirror by one accepted request and queue what it should produce.
   function automatic void deframe_request(bit restart, logic [7:0] b);
      logic [7:0] plain;
      if (restart) begin
         rx_phase  = PH_HEADER;
         rx_index  = '0;
         rx_opcode = '0;
         rx_length = '0;
         rx_mask   = '{default: 8'h00};
         return;
      end
      case (rx_phase) inside
         PH_HEADER: begin
            if (rx_index == 0) begin
               rx_opcode = b[3:0];
               if (rx_opcode == CloseOpcode) begin
                  rx_phase = PH_DONE;
                  push_decode(KIND_CLOSE, 8'h00, 1'b1);
               end else begin
                  rx_index = 64'd1;
               end
            end else begin
               rx_index = '0;
               if (b[6:0] == Len16Code) begin
                  rx_length = '0;
                  rx_phase  = PH_LEN16;
               end else if (b[6:0] == Len64Code) begin
                  rx_length = '0;
                  rx_phase  = PH_LEN64;
               end else begin
                  rx_length = len_type'(b[6:0]);
                  if (!b[7] && b[6:0] == 7'd0) begin
                     rx_phase = PH_HEADER;
                     push_decode(KIND_EMPTY, 8'h00, 1'b1);
                  end else begin
                     rx_phase = b[7] ? PH_MASK : PH_PAYLOAD;
                  end
               end
            end
         end
         PH_LEN16, PH_LEN64: begin
            rx_length = (rx_length << 8) | len_type'(b);
            rx_index++;
            if (rx_index >= ((rx_phase == PH_LEN16) ? 2 : 8)) begin
               rx_phase = PH_MASK;
               rx_index = '0;
            end
         end
         PH_MASK: begin
            rx_mask[rx_index[1:0]] = b;
            rx_index++;
            if (rx_index >= 4) begin
               rx_index = '0;
               if (rx_length == 0) begin
                  rx_phase = PH_HEADER;
                  push_decode(KIND_EMPTY, 8'h00, 1'b1);
               end else begin
                  rx_phase = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            plain = b ^ rx_mask[rx_index[1:0]];
            rx_index++;
            if (rx_index >= 64'(rx_length)) begin
               rx_phase = PH_HEADER;
               rx_index = '0;
               push_decode(KIND_DATA, plain, 1'b1);
            end else begin
               push_decode(KIND_DATA, plain, 1'b0);
            end
         end
         default: push_decode(KIND_ERROR, 8'h00, 1'b1);
      endcase
   endfunction

   task automatic send_request(input bit restart, input logic [7:0] b);
      int gap;
      gap = idle_on ? $urandom_range(0, 3) : 0;
      repeat (gap) @(negedge clock) req_tvalid <= 1'b0;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= restart;
      do @(posedge clock); while (!req_tready);
      deframe_request(restart, b);
      requests_sent++;
   endtask

   task automatic send_bytes(input logic [7:0] list[$]);
      foreach (list[i]) send_request(1'b0, list[i]);
   endtask

   task automatic send_frame_prefix(input int count);
      for (int i = 0; i < count && i < frame_bytes.size(); i++)
         send_request(1'b0, frame_bytes[i]);
   endtask

   // form: 0 seven-bit length, 1 16-bit extended, 2 64-bit extended
   function automatic void build_data_frame(int unsigned plen, int form, bit masked);
      logic [3:0]  opc;
      logic [63:0] len64;
      frame_bytes.delete();
      do opc = 4'($urandom); while (opc == CloseOpcode);
      add_frame_byte({4'($urandom), opc});
      len64 = 64'(plen);
      case (form)
         0: add_frame_byte({masked, 7'(plen)});
         1: begin
            add_frame_byte({masked, Len16Code});
            for (int i = 1; i >= 0; i--) add_frame_byte(len64[8*i +: 8]);
         end
         default: begin
            add_frame_byte({masked, Len64Code});
            for (int i = 7; i >= 0; i--) add_frame_byte(len64[8*i +: 8]);
         end
      endcase
      // extended lengths are always followed by a key
      if (masked || form != 0) repeat (4) add_frame_byte(8'($urandom));
      repeat (plen) add_frame_byte(8'($urandom));
   endfunction

   function automatic void build_random_frame();
      int pick;
      pick = $urandom_range(0, 39);
      if (pick == 0)
         build_data_frame($urandom_range(100, 125), 0, 1'($urandom_range(0, 1)));
      else if (pick == 1)
         build_data_frame($urandom_range(126, 140), 1, 1'($urandom_range(0, 1)));
      else if (pick < 26)
         build_data_frame($urandom_range(0, 10), 0, 1'($urandom_range(0, 1)));
      else if (pick < 33)
         build_data_frame($urandom_range(0, 16), 1, 1'($urandom_range(0, 1)));
      else
         build_data_frame($urandom_range(0, 16), 2, 1'($urandom_range(0, 1)));
   endfunction

   // Result checker; also draws the receiver's gap after each accepted result.
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pending_decodes.size() == 0) begin
            report_mismatch("result with none expected", rsp_tdata, 16'h0);
         end else begin
            want = pending_decodes.pop_front();
            kind_seen[want.kind]++;
            if (rsp_tuser != want.kind)
               report_mismatch("kind", 16'(rsp_tuser), 16'(want.kind));
            if (rsp_tdata[7:0] != want.payload_byte)
               report_mismatch("payload_byte", 16'(rsp_tdata[7:0]),
                               16'(want.payload_byte));
            if (rsp_tdata[11:8] != want.frame_opcode)
               report_mismatch("frame_opcode", 16'(rsp_tdata[11:8]),
                               16'(want.frame_opcode));
            if (rsp_tlast != want.last)
               report_mismatch("last", 16'(rsp_tlast), 16'(want.last));
         end
         rsp_wait = idle_on ? $urandom_range(0, 3) : 0;
      end
   end

   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else if (rsp_wait > 0) begin
         rsp_wait--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("Timeout after %0d cycles, %0d results still expected",
                  cycle_count, pending_decodes.size());
         $display("FAIL websocket_frame_deframer");
         $finish;
      end
   end

   // Masked and unmasked seven-bit frames, including the unmasked zero-length empty frame.
   task automatic test_short_frames();
      // masked, len 2, key extremes
      send_bytes('{8'h81, 8'h82, 8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h00, 8'hFF});
      // unmasked with reserved bits set: reuses the stored key
      send_bytes('{8'h72, 8'h01, 8'h3C});
      // unmasked zero length: empty at once
      send_bytes('{8'h09, 8'h00});
   endtask

   // 16-bit length with the mask bit clear still reads a key; zero length gives empty.
   task automatic test_extended_length();
      send_bytes('{8'h8A, 8'h7E, 8'h00, 8'h00, 8'h11, 8'h22, 8'h33, 8'h44});
   endtask

   task automatic test_close_and_restart();
      send_bytes('{8'h88, 8'hFF});
      send_request(1'b1, 8'hFF);
   endtask

   // Receiver holds off while a long frame streams in, so the output queue fills.
   task automatic test_output_backpressure();
      idle_on = 1'b0;
      rsp_hold = 80;
      build_data_frame(30, 0, 1'b1);
      send_frame_prefix(frame_bytes.size());
      idle_on = 1'b1;
   endtask

   task automatic test_random_stream();
      int pick;
      int stop_at;
      stop_at = requests_sent + RandomItems;
      while (requests_sent < stop_at) begin
         idle_on = ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            build_random_frame();
            send_frame_prefix(frame_bytes.size());
         end else if (pick < 80) begin
            // frame cut short anywhere, then restart
            build_random_frame();
            send_frame_prefix($urandom_range(1, frame_bytes.size()));
            send_request(1'b1, 8'($urandom));
         end else if (pick < 88) begin
            send_request(1'b0, {4'($urandom), CloseOpcode});
            repeat ($urandom_range(0, 3)) send_request(1'b0, 8'($urandom));
            send_request(1'b1, 8'($urandom));
         end else if (pick < 94) begin
            // 64-bit length with the top bits set never finishes
            build_data_frame(8, 2, 1'($urandom_range(0, 1)));
            for (int i = 2; i < 10; i++) frame_bytes[i] = 8'($urandom);
            frame_bytes[2][7] = 1'b1;
            send_frame_prefix($urandom_range(10, frame_bytes.size()));
            send_request(1'b1, 8'($urandom));
         end else begin
            repeat ($urandom_range(1, 6)) send_request(1'b0, 8'($urandom));
            send_request(1'b1, 8'($urandom));
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      test_short_frames();
      test_extended_length();
      test_close_and_restart();
      test_output_backpressure();
      test_random_stream();

      @(negedge clock) req_tvalid <= 1'b0;
      while (pending_decodes.size() > 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d requests, checked %0d results", requests_sent, results_seen);
      $display("Results by kind: payload %0d, empty %0d, close %0d, error %0d",
               kind_seen[KIND_DATA], kind_seen[KIND_EMPTY], kind_seen[KIND_CLOSE],
               kind_seen[KIND_ERROR]);
      if (error_count == 0 && pending_decodes.size() == 0) begin
         $display("PASS websocket_frame_deframer");
      end else begin
         $display("FAIL websocket_frame_deframer");
      end
      $finish;
   end

endmodule
